// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define TCPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define TCPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/core/tcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpc_pkg
// Types and constants shared by the text console put-char engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpc_pkg;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = COLUMNS * ROWS;
  localparam int ADDR_W        = $clog2(CELLS);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int CHAR_W        = 8;
  localparam int POS_W         = 11;
  localparam int IDX_W         = 11;

  localparam logic [CHAR_W-1:0] BLANK_ATTR   = 8'h0F;
  localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'h0A;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_CLEAR,
    OP_READ,
    OP_SETCUR
  } op_e;

  typedef struct packed {
    op_e               opcode;
    logic [CHAR_W-1:0] char_byte;
    logic [IDX_W-1:0]  cell_index;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] read_attr;
    logic              scrolled;
  } rsp_t;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ,
    CMD_SETCUR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              in_range;
    logic [CHAR_W-1:0] ch;
    addr_t             idx;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } bk_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SETCUR,
    ST_SCROLL,
    ST_SCROLL_LAST,
    ST_FILL
  } state_e;

  typedef enum logic [1:0] {
    FILL_INIT,
    FILL_CLEAR,
    FILL_SCROLL
  } fill_e;

endpackage

`default_nettype wire

// ===== rtl/core/tcpc_ram.sv =====
// ----------------------------------------------------------------------------
// tcpc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/tcpc_front.sv =====
// ----------------------------------------------------------------------------
// tcpc_front
// Accepts requests, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpc_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_stall_o,
  input  wire tcpc_pkg::req_t      req_i,
  input  wire tcpc_pkg::bk_status_t bk_status_i,
  output logic                     cmd_valid_o,
  output tcpc_pkg::cmd_t           cmd_o
);

  tcpc_pkg::cmd_t                  cmd_in;
  tcpc_pkg::cmd_t                  ent_q [tcpc_pkg::QUEUE_DEPTH];
  logic [tcpc_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [tcpc_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [tcpc_pkg::QPTR_W:0]       count_q, count_d;
  logic                            full;
  logic                            push;
  logic                            pop;

  // classify
  always_comb begin
    cmd_in.ch       = req_i.char_byte;
    cmd_in.idx      = tcpc_pkg::ADDR_W'(req_i.cell_index);
    cmd_in.in_range = (32'(req_i.cell_index) < tcpc_pkg::CELLS);
    unique case (req_i.opcode)
      tcpc_pkg::OP_PUT: begin
        cmd_in.kind = (req_i.char_byte == tcpc_pkg::NEWLINE_BYTE) ?
                      tcpc_pkg::CMD_NEWLINE : tcpc_pkg::CMD_WRITE;
      end
      tcpc_pkg::OP_CLEAR:  cmd_in.kind = tcpc_pkg::CMD_CLEAR;
      tcpc_pkg::OP_READ:   cmd_in.kind = tcpc_pkg::CMD_READ;
      tcpc_pkg::OP_SETCUR: cmd_in.kind = tcpc_pkg::CMD_SETCUR;
    endcase
  end

  assign full        = (count_q == (tcpc_pkg::QPTR_W + 1)'(tcpc_pkg::QUEUE_DEPTH));
  assign req_stall_o = full || bk_status_i.init_busy;
  assign push        = req_valid_i && !req_stall_o;
  assign pop         = bk_status_i.pop;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tcpc_pkg::QPTR_W'(tcpc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + tcpc_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == tcpc_pkg::QPTR_W'(tcpc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + tcpc_pkg::QPTR_W'(1);
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + (tcpc_pkg::QPTR_W + 1)'(1);
      2'b01:   count_d = count_q - (tcpc_pkg::QPTR_W + 1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tcpc_back.sv =====
// ----------------------------------------------------------------------------
// tcpc_back
// Executes queued commands on the character grid and holds the cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpc_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  input  wire tcpc_pkg::cmd_t       cmd_i,
  output tcpc_pkg::bk_status_t      bk_status_o,
  output logic                      rsp_valid_o,
  input  wire logic                 rsp_stall_i,
  output tcpc_pkg::rsp_t            rsp_o
);

  tcpc_pkg::state_e             state_q, state_d;
  tcpc_pkg::fill_e              fill_kind_q, fill_kind_d;
  tcpc_pkg::addr_t              ptr_q, ptr_d;
  tcpc_pkg::addr_t              idx_q, idx_d;
  tcpc_pkg::addr_t              cursor_q, cursor_d;
  tcpc_pkg::addr_t              row_base_q, row_base_d;
  tcpc_pkg::addr_t              mv_addr_q, mv_addr_d;
  logic                         mv_valid_q, mv_valid_d;
  logic                         rsp_valid_q;
  tcpc_pkg::rsp_t               rsp_q, rsp_d;

  logic                         rsp_free;
  logic                         pop;
  logic                         ld;
  logic [tcpc_pkg::ADDR_W:0]    row_end;
  logic [tcpc_pkg::ADDR_W:0]    base_end;

  logic                         ram_we;
  tcpc_pkg::addr_t              ram_waddr;
  logic [tcpc_pkg::CHAR_W-1:0]  ram_wdata;
  logic                         ram_re;
  tcpc_pkg::addr_t              ram_raddr;
  logic [tcpc_pkg::CHAR_W-1:0]  ram_rdata;

  tcpc_ram #(
    .WIDTH (tcpc_pkg::CHAR_W),
    .DEPTH (tcpc_pkg::CELLS)
  ) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rsp_free = !rsp_valid_q || !rsp_stall_i;
  assign row_end  = {1'b0, row_base_q} + (tcpc_pkg::ADDR_W + 1)'(tcpc_pkg::COLUMNS);
  assign base_end = {1'b0, ptr_q} + (tcpc_pkg::ADDR_W + 1)'(tcpc_pkg::COLUMNS);

  always_comb begin
    state_d     = state_q;
    fill_kind_d = fill_kind_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    cursor_d    = cursor_q;
    row_base_d  = row_base_q;
    mv_addr_d   = mv_addr_q;
    mv_valid_d  = 1'b0;
    pop         = 1'b0;
    ld          = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;
    rsp_d       = '0;

    unique case (state_q)
      tcpc_pkg::ST_IDLE: begin
        if (cmd_valid_i && rsp_free) begin
          pop = 1'b1;
          unique case (cmd_i.kind)
            tcpc_pkg::CMD_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = cursor_q;
              ram_wdata = cmd_i.ch;
              if (cursor_q == tcpc_pkg::ADDR_W'(tcpc_pkg::CELLS - 1)) begin
                ptr_d   = tcpc_pkg::ADDR_W'(tcpc_pkg::COLUMNS);
                state_d = tcpc_pkg::ST_SCROLL;
              end else begin
                cursor_d = cursor_q + tcpc_pkg::ADDR_W'(1);
                if ({1'b0, cursor_d} == row_end) begin
                  row_base_d = tcpc_pkg::ADDR_W'(row_end);
                end
                ld = 1'b1;
              end
            end
            tcpc_pkg::CMD_NEWLINE: begin
              if (row_base_q == tcpc_pkg::ADDR_W'(tcpc_pkg::LAST_ROW_BASE)) begin
                ptr_d   = tcpc_pkg::ADDR_W'(tcpc_pkg::COLUMNS);
                state_d = tcpc_pkg::ST_SCROLL;
              end else begin
                cursor_d   = tcpc_pkg::ADDR_W'(row_end);
                row_base_d = tcpc_pkg::ADDR_W'(row_end);
                ld         = 1'b1;
              end
            end
            tcpc_pkg::CMD_CLEAR: begin
              ptr_d       = '0;
              fill_kind_d = tcpc_pkg::FILL_CLEAR;
              state_d     = tcpc_pkg::ST_FILL;
            end
            tcpc_pkg::CMD_READ: begin
              if (cmd_i.in_range) begin
                ram_re    = 1'b1;
                ram_raddr = cmd_i.idx;
                state_d   = tcpc_pkg::ST_READ;
              end else begin
                ld = 1'b1;
              end
            end
            tcpc_pkg::CMD_SETCUR: begin
              if (cmd_i.in_range) begin
                ptr_d   = '0;
                idx_d   = cmd_i.idx;
                state_d = tcpc_pkg::ST_SETCUR;
              end else begin
                ld = 1'b1;
              end
            end
            default: ld = 1'b1;
          endcase
        end
      end
      tcpc_pkg::ST_READ: begin
        ld              = 1'b1;
        rsp_d.read_char = ram_rdata;
        rsp_d.read_attr = tcpc_pkg::BLANK_ATTR;
        state_d         = tcpc_pkg::ST_IDLE;
      end
      tcpc_pkg::ST_SETCUR: begin
        // step the row base until it holds the target cell
        if ({1'b0, idx_q} >= base_end) begin
          ptr_d = tcpc_pkg::ADDR_W'(base_end);
        end else begin
          cursor_d   = idx_q;
          row_base_d = ptr_q;
          ld         = 1'b1;
          state_d    = tcpc_pkg::ST_IDLE;
        end
      end
      tcpc_pkg::ST_SCROLL: begin
        // read one row below, write it back in the next cycle one row up
        ram_re     = 1'b1;
        ram_raddr  = ptr_q;
        mv_valid_d = 1'b1;
        mv_addr_d  = ptr_q - tcpc_pkg::ADDR_W'(tcpc_pkg::COLUMNS);
        if (mv_valid_q) begin
          ram_we    = 1'b1;
          ram_waddr = mv_addr_q;
          ram_wdata = ram_rdata;
        end
        if (ptr_q == tcpc_pkg::ADDR_W'(tcpc_pkg::CELLS - 1)) begin
          state_d = tcpc_pkg::ST_SCROLL_LAST;
        end else begin
          ptr_d = ptr_q + tcpc_pkg::ADDR_W'(1);
        end
      end
      tcpc_pkg::ST_SCROLL_LAST: begin
        ram_we      = mv_valid_q;
        ram_waddr   = mv_addr_q;
        ram_wdata   = ram_rdata;
        ptr_d       = tcpc_pkg::ADDR_W'(tcpc_pkg::LAST_ROW_BASE);
        fill_kind_d = tcpc_pkg::FILL_SCROLL;
        state_d     = tcpc_pkg::ST_FILL;
      end
      tcpc_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = '0;
        if (ptr_q == tcpc_pkg::ADDR_W'(tcpc_pkg::CELLS - 1)) begin
          state_d = tcpc_pkg::ST_IDLE;
          if (fill_kind_q == tcpc_pkg::FILL_SCROLL) begin
            cursor_d       = tcpc_pkg::ADDR_W'(tcpc_pkg::LAST_ROW_BASE);
            row_base_d     = tcpc_pkg::ADDR_W'(tcpc_pkg::LAST_ROW_BASE);
            rsp_d.scrolled = 1'b1;
            ld             = 1'b1;
          end else if (fill_kind_q == tcpc_pkg::FILL_CLEAR) begin
            ld = 1'b1;
          end
        end else begin
          ptr_d = ptr_q + tcpc_pkg::ADDR_W'(1);
        end
      end
      default: state_d = tcpc_pkg::ST_IDLE;
    endcase

    rsp_d.cursor_pos = tcpc_pkg::POS_W'(cursor_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcpc_pkg::ST_FILL;
      fill_kind_q <= tcpc_pkg::FILL_INIT;
      ptr_q       <= '0;
      cursor_q    <= '0;
      row_base_q  <= '0;
      mv_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_kind_q <= fill_kind_d;
      ptr_q       <= ptr_d;
      cursor_q    <= cursor_d;
      row_base_q  <= row_base_d;
      mv_valid_q  <= mv_valid_d;
      if (ld) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    mv_addr_q <= mv_addr_d;
    if (ld) begin
      rsp_q <= rsp_d;
    end
  end

  assign bk_status_o.pop       = pop;
  assign bk_status_o.init_busy = (state_q == tcpc_pkg::ST_FILL) &&
                                 (fill_kind_q == tcpc_pkg::FILL_INIT);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/text_console_put_char_engine_top.sv =====
// ----------------------------------------------------------------------------
// text_console_put_char_engine_top
// Text console engine: character grid, cursor, put/clear/read/set-cursor.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue at up to one per cycle while it is
// not full; the back end serves one command at a time from a single-port-write
// character RAM with registered read, and each request yields one response. An
// ordinary character or a newline that does not scroll is done in the idle
// state, as are out-of-range reads and cursor moves; an in-range read waits
// in a read state for the registered RAM output; an in-range set cursor finds
// its row by stepping the row base one row a cycle. A scroll copies one cell
// a cycle and then blanks the last row; a clear blanks one cell a cycle. After
// reset a clearing pass runs while requests are stalled. Attributes are not
// stored; an in-range read reports 0x0F.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_put_char_engine_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire tcpc_pkg::req_t req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output tcpc_pkg::rsp_t      rsp_o
);

  logic                 cmd_valid;
  tcpc_pkg::cmd_t       cmd;
  tcpc_pkg::bk_status_t bk_status;

  tcpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .bk_status_i (bk_status),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  tcpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .bk_status_o (bk_status),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/tcpc_checker.sv =====
// ----------------------------------------------------------------------------
// tcpc_checker
// Port-level assertions for the text console engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcpc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           req_valid_i,
  input wire logic           req_stall_o,
  input wire tcpc_pkg::req_t req_i,
  input wire logic           rsp_valid_o,
  input wire logic           rsp_stall_i,
  input wire tcpc_pkg::rsp_t rsp_o
);

  logic req_held;
  logic rsp_held;
  logic scroll_rsp;
  logic scroll_pos_ok;
  logic attr_ok;

  assign req_held      = req_valid_i && req_stall_o;
  assign rsp_held      = rsp_valid_o && rsp_stall_i;
  assign scroll_rsp    = rsp_valid_o && rsp_o.scrolled;
  assign scroll_pos_ok = (rsp_o.cursor_pos == tcpc_pkg::POS_W'(tcpc_pkg::LAST_ROW_BASE));
  assign attr_ok       = (rsp_o.read_attr == '0) || (rsp_o.read_attr == tcpc_pkg::BLANK_ATTR);

  `TCPC_ASSERT(a_req_holds, req_held |=> req_valid_i && $stable(req_i), "request changed")
  `TCPC_ASSERT(a_rsp_valid_holds, rsp_held |=> rsp_valid_o, "response dropped while stalled")
  `TCPC_ASSERT(a_rsp_payload_holds, rsp_held |=> $stable(rsp_o), "stalled response changed")
  `TCPC_ASSERT(a_scroll_cursor, scroll_rsp |-> scroll_pos_ok, "scroll left cursor off last row")
  `TCPC_ASSERT_ALWAYS(a_attr_code, rsp_valid_o |-> attr_ok, "unexpected attribute")

endmodule

bind text_console_put_char_engine_top tcpc_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for text_console_put_char_engine_top. A clocked driver
// sends requests from a backlog filled at time zero: a directed opening
// (field extremes, every opcode, scrolls by newline and by last-cell write,
// out-of-range read and set cursor, clear), then random traffic biased
// toward the bottom rows. A shadow copy of the character grid, attributes
// and cursor predicts each response. A clocked monitor checks responses in
// order. Both sides idle at random, with idle-free stretches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import tcpc_pkg::*;

  localparam int unsigned HANG_LIMIT = 25000;
  localparam int unsigned MAX_IDLE   = 17;
  localparam int unsigned RAND_REQS  = 800;
  localparam int unsigned END_WAIT   = 50;

  typedef struct {
    req_t        req;
    int unsigned gap;
    bit          drain;
  } backlog_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  backlog_t    req_backlog_q[$];
  rsp_t        console_rsp_q[$];
  logic [7:0]  shadow_char[CELLS];
  logic [7:0]  shadow_attr[CELLS];
  logic [POS_W-1:0] shadow_cursor;

  int unsigned req_sent    = 0;
  int unsigned rsp_seen    = 0;
  int unsigned err_cnt     = 0;
  int unsigned quiet_cnt   = 0;
  int unsigned drv_idle    = 0;
  bit          gap_taken   = 1'b0;
  bit          drv_calm    = 1'b0;
  bit          mon_calm    = 1'b0;
  int unsigned hold_cnt    = 0;
  int unsigned hold_draw;
  bit          nxt_valid;
  bit          slot_free;
  rsp_t        want;

  text_console_put_char_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_stall_o (req_stall),
    .req_i       (req_data),
    .rsp_valid_o (rsp_valid),
    .rsp_stall_i (rsp_stall),
    .rsp_o       (rsp_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void scroll_shadow();
    for (int i = 0; i < CELLS - COLUMNS; i++) shadow_char[i] = shadow_char[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) shadow_char[i] = 8'h00;
  endfunction

  function automatic void apply_console_req(req_t r);
    rsp_t        e;
    int unsigned row;
    e = '0;
    if (shadow_cursor >= CELLS) shadow_cursor = '0;
    case (r.opcode)
      OP_PUT: begin
        if (r.char_byte == NEWLINE_BYTE) begin
          row = shadow_cursor / COLUMNS;
          if (row >= ROWS - 1) begin
            scroll_shadow();
            e.scrolled    = 1'b1;
            shadow_cursor = POS_W'(LAST_ROW_BASE);
          end else begin
            shadow_cursor = POS_W'((row + 1) * COLUMNS);
          end
        end else begin
          shadow_char[shadow_cursor] = r.char_byte;
          if (shadow_cursor == CELLS - 1) begin
            scroll_shadow();
            e.scrolled    = 1'b1;
            shadow_cursor = POS_W'(LAST_ROW_BASE);
          end else begin
            shadow_cursor = shadow_cursor + 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          shadow_char[i] = 8'h00;
          shadow_attr[i] = BLANK_ATTR;
        end
      end
      OP_READ: begin
        if (r.cell_index < CELLS) begin
          e.read_char = shadow_char[r.cell_index];
          e.read_attr = shadow_attr[r.cell_index];
        end
      end
      OP_SETCUR: begin
        if (r.cell_index < CELLS) shadow_cursor = POS_W'(r.cell_index);
      end
      default: ;
    endcase
    e.cursor_pos = shadow_cursor;
    console_rsp_q.push_back(e);
  endfunction

  function automatic void add_req(op_e op, int unsigned ch, int unsigned idx, bit drain);
    backlog_t b;
    if ($urandom_range(39, 0) == 0) drv_calm = !drv_calm;
    b.req.opcode     = op;
    b.req.char_byte  = ch[CHAR_W-1:0];
    b.req.cell_index = idx[IDX_W-1:0];
    b.gap            = drv_calm ? 0 : $urandom_range(MAX_IDLE, 0);
    b.drain          = drain;
    req_backlog_q.push_back(b);
  endfunction

  function automatic int unsigned pick_cell();
    int unsigned sel;
    sel = $urandom_range(99, 0);
    if (sel < 40) return $urandom_range(CELLS - 1, CELLS - 2 * COLUMNS);
    if (sel < 85) return $urandom_range(CELLS - 1, 0);
    return $urandom_range((1 << IDX_W) - 1, 0);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_data  <= '0;
      drv_idle  <= 0;
      gap_taken <= 1'b0;
    end else begin
      slot_free = !req_valid || !req_stall;
      nxt_valid = req_valid && req_stall;
      if (req_valid && !req_stall) begin
        apply_console_req(req_data);
        req_sent <= req_sent + 1;
      end
      if (slot_free) begin
        if (drv_idle != 0) begin
          drv_idle <= drv_idle - 1;
        end else if (req_backlog_q.size() != 0) begin
          if (req_backlog_q[0].drain &&
              ((req_sent != rsp_seen) || (req_valid && !req_stall))) begin
          end else if (!gap_taken && req_backlog_q[0].gap != 0) begin
            drv_idle  <= req_backlog_q[0].gap - 1;
            gap_taken <= 1'b1;
          end else begin
            req_data  <= req_backlog_q[0].req;
            nxt_valid = 1'b1;
            gap_taken <= 1'b0;
            void'(req_backlog_q.pop_front());
          end
        end
      end
      req_valid <= nxt_valid;
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_seen <= rsp_seen + 1;
      if (console_rsp_q.size() == 0) begin
        err_cnt = err_cnt + 1;
        if (err_cnt <= 10) $display("unexpected response: %p", rsp_data);
      end else begin
        want = console_rsp_q.pop_front();
        if (rsp_data.cursor_pos !== want.cursor_pos || rsp_data.read_char !== want.read_char ||
            rsp_data.read_attr !== want.read_attr || rsp_data.scrolled !== want.scrolled) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= 10)
            $display("mismatch #%0d: cursor %0d/%0d char %h/%h attr %h/%h scrolled %b/%b",
                     rsp_seen, want.cursor_pos, rsp_data.cursor_pos, want.read_char,
                     rsp_data.read_char, want.read_attr, rsp_data.read_attr,
                     want.scrolled, rsp_data.scrolled);
        end
      end
      if ($urandom_range(39, 0) == 0) mon_calm = !mon_calm;
      hold_draw = mon_calm ? 0 : $urandom_range(MAX_IDLE, 0);
      hold_cnt  <= hold_draw;
      rsp_stall <= (hold_draw != 0);
    end else if (rsp_valid && hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      rsp_stall <= (hold_cnt != 1);
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= HANG_LIMIT) begin
      $display("text_console_put_char_engine_top test failed");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    int unsigned ch;
    int unsigned idx;
    op_e         op;

    for (int i = 0; i < CELLS; i++) begin
      shadow_char[i] = 8'h00;
      shadow_attr[i] = BLANK_ATTR;
    end
    shadow_cursor = '0;

    // directed opening
    add_req(OP_PUT, 8'h48, 2047, 1'b0);
    add_req(OP_PUT, 8'h00, 0, 1'b0);
    add_req(OP_PUT, 8'hFF, 1234, 1'b0);
    add_req(OP_READ, 8'hFF, 0, 1'b0);
    add_req(OP_READ, 8'h00, 2, 1'b0);
    add_req(OP_READ, 8'h0A, CELLS - 1, 1'b0);
    add_req(OP_READ, 8'h00, CELLS, 1'b0);
    add_req(OP_READ, 8'h00, 2047, 1'b0);
    add_req(OP_SETCUR, 8'hFF, 2047, 1'b0);
    add_req(OP_SETCUR, 8'h00, CELLS, 1'b0);
    add_req(OP_SETCUR, 8'h0A, COLUMNS - 1, 1'b0);
    add_req(OP_PUT, 8'h78, 0, 1'b0);
    add_req(OP_PUT, NEWLINE_BYTE, 2047, 1'b0);
    add_req(OP_SETCUR, 8'h00, CELLS - 1, 1'b0);
    add_req(OP_PUT, 8'h55, 0, 1'b0);
    add_req(OP_READ, 8'h00, LAST_ROW_BASE - 1, 1'b0);
    add_req(OP_READ, 8'h00, CELLS - 1, 1'b0);
    add_req(OP_PUT, NEWLINE_BYTE, 0, 1'b0);
    add_req(OP_SETCUR, 8'h00, LAST_ROW_BASE - 1, 1'b0);
    add_req(OP_PUT, NEWLINE_BYTE, 0, 1'b0);
    add_req(OP_CLEAR, 8'hFF, 2047, 1'b0);
    add_req(OP_READ, 8'h00, LAST_ROW_BASE - 1, 1'b0);
    add_req(OP_PUT, NEWLINE_BYTE, 0, 1'b1);
    add_req(OP_PUT, 8'hAA, 0, 1'b0);
    add_req(OP_READ, 8'h00, LAST_ROW_BASE, 1'b0);

    for (int n = 0; n < RAND_REQS; n++) begin
      sel = $urandom_range(99, 0);
      ch  = $urandom_range(255, 0);
      idx = $urandom_range((1 << IDX_W) - 1, 0);
      if (sel < 55) begin
        op = OP_PUT;
      end else if (sel < 75) begin
        op  = OP_READ;
        idx = pick_cell();
      end else if (sel < 90) begin
        op  = OP_SETCUR;
        idx = pick_cell();
        if ($urandom_range(2, 0) == 0) idx = $urandom_range(CELLS - 1, CELLS - 10);
      end else if (sel < 98) begin
        op = OP_PUT;
        ch = NEWLINE_BYTE;
      end else begin
        op = OP_CLEAR;
      end
      add_req(op, ch, idx, n == RAND_REQS / 2);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog_q.size() != 0 || req_valid) @(posedge clk_i);
    while (req_sent != rsp_seen) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);

    if (err_cnt == 0 && console_rsp_q.size() == 0) begin
      $display("text_console_put_char_engine_top test passed");
    end else begin
      $display("text_console_put_char_engine_top test failed");
    end
    $finish;
  end

endmodule
